// ===== rtl/rwa_pkg.sv =====
`default_nettype none

package rwa_pkg;

   localparam int SAMPLE_BITS  = 16;
   localparam int CFG_W        = 11;
   localparam int LEVEL_W      = 11;
   localparam int WINDOW_RESET = 100;
   localparam int STEP_W       = 3;

   // microprogram addresses
   localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TRIM   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ACCUM  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DIVIDE = 3'd3;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_RETURN = 3'd5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_TRIM,
      OP_ACCUM,
      OP_DIVIDE,
      OP_EMIT
   } rwa_op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_DIV_BUSY,
      COND_OUT_FULL
   } rwa_cond_type;

   typedef struct packed {
      rwa_op_type          op;
      logic                take;
      rwa_cond_type        cond;
      logic [STEP_W-1:0]   target;
   } rwa_ctl_type;

   typedef struct packed {
      logic req_valid;
      logic div_busy;
      logic out_full;
   } rwa_stat_type;

   // control store: jump to target when cond holds, else fall through
   function automatic rwa_ctl_type rwa_ucode(input logic [STEP_W-1:0] step);
      rwa_ctl_type w;
      unique case (step)
         STEP_FETCH:  w = '{OP_LOAD,   1'b1, COND_NO_REQ,   STEP_FETCH};
         STEP_TRIM:   w = '{OP_TRIM,   1'b0, COND_NEVER,    STEP_FETCH};
         STEP_ACCUM:  w = '{OP_ACCUM,  1'b0, COND_NEVER,    STEP_FETCH};
         STEP_DIVIDE: w = '{OP_DIVIDE, 1'b0, COND_DIV_BUSY, STEP_DIVIDE};
         STEP_EMIT:   w = '{OP_EMIT,   1'b0, COND_OUT_FULL, STEP_EMIT};
         STEP_RETURN: w = '{OP_NONE,   1'b0, COND_ALWAYS,   STEP_FETCH};
         default:     w = '{OP_NONE,   1'b0, COND_ALWAYS,   STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rwa_if.sv =====
`default_nettype none

interface rwa_req_if;
   logic                             valid;
   logic                             ready;
   logic [rwa_pkg::SAMPLE_BITS-1:0]  sample;
   logic                             restart;

   modport source (output valid, output sample, output restart, input ready);
   modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface rwa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rwa_pkg::SAMPLE_BITS-1:0]  average;
   logic [rwa_pkg::LEVEL_W-1:0]      fill_level;

   modport source (output valid, output average, output fill_level, input ready);
   modport sink   (input valid, input average, input fill_level, output ready);
endinterface

interface rwa_csr_if;
   logic                        valid;
   logic                        ready;
   logic [rwa_pkg::CFG_W-1:0]   window_length;

   modport source (output valid, output window_length, input ready);
   modport sink   (input valid, input window_length, output ready);
endinterface

`default_nettype wire

// ===== rtl/rwa_ram.sv =====
`default_nettype none

module rwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output      logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/rwa_seq.sv =====
`default_nettype none

module rwa_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rwa_pkg::rwa_stat_type  stat,
   output      rwa_pkg::rwa_ctl_type   ctl
);

   import rwa_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              jump;

   assign ctl = rwa_ucode(step_ff);

   always_comb begin
      unique case (ctl.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !stat.req_valid;
         COND_DIV_BUSY: jump = stat.div_busy;
         COND_OUT_FULL: jump = stat.out_full;
         default:       jump = 1'b1;
      endcase
      step_in = jump ? ctl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rwa_datapath.sv =====
`default_nettype none

module rwa_datapath #(
   parameter int MAX_WINDOW = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire rwa_pkg::rwa_ctl_type                  ctl,
   input  wire logic [$clog2(MAX_WINDOW+1)-1:0]       len,
   input  wire logic                                  req_valid,
   input  wire logic [rwa_pkg::SAMPLE_BITS-1:0]       req_sample,
   input  wire logic                                  req_restart,
   input  wire logic                                  rsp_ready,
   output      rwa_pkg::rwa_stat_type                 stat,
   output      logic                                  rsp_valid,
   output      logic [rwa_pkg::SAMPLE_BITS-1:0]       rsp_average,
   output      logic [rwa_pkg::LEVEL_W-1:0]           rsp_fill_level
);

   import rwa_pkg::*;

   localparam int FW     = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W = $clog2(MAX_WINDOW);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int CNT_W  = $clog2(SUM_W);
   localparam logic [SUM_W-1:0] SUM_MAX =
      SUM_W'(MAX_WINDOW * (2 ** SAMPLE_BITS - 1));
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SUM_W-1:0]       div_q_ff, div_q_in;
   logic [FW-1:0]          div_rem_ff, div_rem_in;
   logic [CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [LEVEL_W-1:0]     level_ff, level_in;

   logic                   load_fire;
   logic                   emit_fire;
   logic                   out_full;
   logic [SLOT_W-1:0]      base_slot;
   logic [SLOT_W-1:0]      load_slot;
   logic [SAMPLE_BITS-1:0] old_sample;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_sat;
   logic [FW:0]            trial;
   logic                   trial_ge;
   logic                   next_wraps;

   assign out_full  = rsp_valid_ff && !rsp_ready;
   assign load_fire = (ctl.op == OP_LOAD) && req_valid;
   assign emit_fire = (ctl.op == OP_EMIT) && !out_full;

   assign stat.req_valid = req_valid;
   assign stat.div_busy  = (div_cnt_ff != '0);
   assign stat.out_full  = out_full;

   // restart empties the window; a slot left past a shrunk window wraps
   assign base_slot = req_restart ? '0 : slot_ff;
   assign load_slot = (FW'(base_slot) >= len) ? '0 : base_slot;

   assign sum_wide   = {1'b0, sum_ff} + (SUM_W+1)'(sample_ff);
   assign sum_sat    = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign next_wraps = (FW'(slot_ff) + 1'b1 >= len);

   // restoring divider, one quotient bit per beat of the loop
   assign trial    = {div_rem_ff, div_q_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, fill_ff});

   rwa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.op == OP_ACCUM),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (load_fire),
      .rd_addr (load_slot),
      .rd_data (old_sample)
   );

   always_comb begin
      fill_in    = fill_ff;
      sum_in     = sum_ff;
      slot_in    = slot_ff;
      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;
      unique case (ctl.op)
         OP_LOAD: begin
            if (load_fire) begin
               fill_in = req_restart ? '0 : fill_ff;
               sum_in  = req_restart ? '0 : sum_ff;
               slot_in = load_slot;
            end
         end
         OP_TRIM: begin
            if (fill_ff < len) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               sum_in = (sum_ff >= SUM_W'(old_sample)) ? sum_ff - SUM_W'(old_sample) : '0;
            end
         end
         OP_ACCUM: begin
            sum_in     = sum_sat;
            slot_in    = next_wraps ? '0 : slot_ff + 1'b1;
            div_q_in   = sum_sat;
            div_rem_in = '0;
            div_cnt_in = CNT_W'(SUM_W - 1);
         end
         OP_DIVIDE: begin
            div_rem_in = trial_ge ? FW'(trial - {1'b0, fill_ff}) : FW'(trial);
            div_q_in   = {div_q_ff[SUM_W-2:0], trial_ge};
            if (div_cnt_ff != '0) begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         OP_NONE, OP_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      avg_in   = (div_q_ff[SUM_W-1:SAMPLE_BITS] != '0) ? SAMPLE_MAX
                                                       : div_q_ff[SAMPLE_BITS-1:0];
      level_in = LEVEL_W'(fill_ff);
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         sum_ff       <= '0;
         slot_ff      <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         slot_ff      <= slot_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         sample_ff <= req_sample;
      end
      div_q_ff   <= div_q_in;
      div_rem_ff <= div_rem_in;
      if (emit_fire) begin
         avg_ff   <= avg_in;
         level_ff <= level_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_average    = avg_ff;
   assign rsp_fill_level = level_ff;

   a_fill_nonzero: assert property (@(posedge clock) disable iff (reset)
      emit_fire |-> fill_ff != '0)
      else $error("result issued with an empty window");

   a_sum_bounded: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= SUM_MAX)
      else $error("running sum above its ceiling");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_DIVIDE |-> div_rem_ff < fill_ff)
      else $error("divider remainder not below divisor");

   a_emit_after_divide: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_DIVIDE && div_cnt_ff == '0) |=> ctl.op == OP_EMIT)
      else $error("divide loop did not hand off to emit");

endmodule

`default_nettype wire

// ===== rtl/running_window_average_top.sv =====
// Sliding-window mean of unsigned Q0.16 samples with warm-up. Each request beat
// carries a sample and a restart flag; restart empties the window first. Until
// window_length samples are held the mean runs over the samples seen so far,
// after that the oldest sample drops out. Every request gives exactly one
// response beat: the truncated mean and the number of samples in the window.
// window_length 0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW; write
// it only while the block is idle. The mean comes from the bit-serial restoring
// divider that produces one quotient bit per cycle under a small microprogram.
// The response register lets the next sample be taken while a result waits.
// The sample ring needs no clearing after reset.
`default_nettype none

module running_window_average_top #(
   parameter int MAX_WINDOW = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rwa_req_if.sink    req_bus,
   rwa_rsp_if.source  rsp_bus,
   rwa_csr_if.sink    csr_bus
);

   import rwa_pkg::*;

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);

   logic [CFG_W-1:0] window_ff;
   logic [LEN_W-1:0] len;
   rwa_ctl_type      ctl;
   rwa_stat_type     stat;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= CFG_W'(WINDOW_RESET);
      end else if (csr_bus.valid) begin
         window_ff <= csr_bus.window_length;
      end
   end

   always_comb begin
      if (window_ff == '0) begin
         len = LEN_W'(1);
      end else if (int'(window_ff) > MAX_WINDOW) begin
         len = LEN_W'(MAX_WINDOW);
      end else begin
         len = LEN_W'(window_ff);
      end
   end

   assign req_bus.ready = ctl.take;

   rwa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   rwa_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .len            (len),
      .req_valid      (req_bus.valid),
      .req_sample     (req_bus.sample),
      .req_restart    (req_bus.restart),
      .rsp_ready      (rsp_bus.ready),
      .stat           (stat),
      .rsp_valid      (rsp_bus.valid),
      .rsp_average    (rsp_bus.average),
      .rsp_fill_level (rsp_bus.fill_level)
   );

endmodule

`default_nettype wire
